### rtl/lrnbw_pkg.sv
// Shared types, constants and constant tables for the LRN backward channel window.
// No dependencies; every file but the checker refers to it by scoped names.
package lrnbw_pkg;

    localparam int MAX_WINDOW = 15;
    localparam int PEND_DEPTH = MAX_WINDOW / 2 + 1;
    localparam int WIN_IDX_W  = $clog2(MAX_WINDOW);
    localparam int PEND_IDX_W = $clog2(PEND_DEPTH);
    localparam int FRAC_BITS  = 24;
    localparam int ITER_W     = $clog2(FRAC_BITS);
    localparam int SUM_W      = 32 + $clog2(MAX_WINDOW) + 1;
    localparam int MUL_W      = 115;
    localparam int CNT_W      = 8;
    localparam int DIV_STEPS  = 63;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    typedef enum logic [1:0] {
        REG_WINDOW_SIZE   = 2'd0,
        REG_ALPHA_SCALE   = 2'd1,
        REG_BETA_EXPONENT = 2'd2
    } reg_idx_t;

    localparam logic [3:0]  WINDOW_SIZE_RST   = 4'd5;
    localparam logic [31:0] ALPHA_SCALE_RST   = 32'd429497;
    localparam logic [15:0] BETA_EXPONENT_RST = 16'd3072;

    typedef struct packed {
        logic [3:0]  window_size;
        logic [31:0] alpha_scale;
        logic [15:0] beta_exponent;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic norm_step;
        logic log_step;
        logic beta_calc;
        logic exp_step;
        logic vmul;
        logic vshift;
        logic push;
        logic plan;
        logic sum_step;
        logic mul_set;
        logic mul_step;
        logic mul2_set;
        logic finish;
        logic out_load;
        logic next_emit;
        logic clear_cnt;
    } dp_cmd_t;

    typedef struct packed {
        logic norm_done;
        logic iter_last;
        logic div_done;
        logic emit_req;
        logic last_item;
        logic sum_done;
        logic mulb_zero;
        logic out_free;
        logic more_emit;
    } dp_status_t;

    typedef enum logic [14:0] {
        ST_IDLE   = 15'b000000000000001,
        ST_NORM   = 15'b000000000000010,
        ST_LOG    = 15'b000000000000100,
        ST_BETA   = 15'b000000000001000,
        ST_EXP    = 15'b000000000010000,
        ST_VMUL   = 15'b000000000100000,
        ST_VSHIFT = 15'b000000001000000,
        ST_WDIV   = 15'b000000010000000,
        ST_PLAN   = 15'b000000100000000,
        ST_SUM    = 15'b000001000000000,
        ST_MSET   = 15'b000010000000000,
        ST_MUL1   = 15'b000100000000000,
        ST_MUL2   = 15'b001000000000000,
        ST_FIN    = 15'b010000000000000,
        ST_OUT    = 15'b100000000000000
    } state_t;

    typedef logic [31:0] root_tbl_t [FRAC_BITS];

    // Integer square root, evaluated only while building the root table.
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] rem;
        int i;
        r   = 64'd0;
        rem = v;
        b   = 64'd1 << 62;
        for (i = 0; i < 32; i++)
        begin
            if (rem >= r + b)
            begin
                rem = rem - (r + b);
                r   = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Entry j holds 2^(2^-(j+1)) in Q2.30, each root taken from the one before.
    function automatic root_tbl_t build_roots();
        root_tbl_t t;
        logic [63:0] r;
        int j;
        r = 64'h8000_0000;
        for (j = 0; j < FRAC_BITS; j++)
        begin
            r    = isqrt64(r << 30);
            t[j] = r[31:0];
        end
        return t;
    endfunction

    localparam root_tbl_t ROOT_TBL = build_roots();

endpackage

### rtl/lrn_backward_channel_window_top.sv
// Top level of the LRN backward channel window: register file, sequencer, datapath.
// Uses lrnbw_pkg, lrnbw_ctrl and lrnbw_datapath.
//
// Channel  | Signals                                            | Beat moves when
// ---------+----------------------------------------------------+---------------------------
// input    | in_valid/in_ready, x_value out_value mid_value     | in_valid & in_ready
//          | out_grad last_channel                              |
// output   | out_valid/out_ready, x_grad last_result            | out_valid & out_ready
// config   | psel penable pwrite paddr pwdata prdata pready     | psel & penable & pwrite
//
// One input beat at a time. The power chain normalises mid (up to 30 leading zeros), runs 24 log2
// squarings, scales by -beta, runs 24 exp2 steps, then multiplies and shifts, while the 63-step
// divider runs alongside; the channel is pushed once the divider is done. Each result then sums
// the window terms (up to 15) and runs the bit-serial correction multiplier over the significant
// bits of |x| and then of |S|; the last channel flushes up to 8 results.
// Reset clears the sequencer, channel count, output valid and registers to defaults.
// A stalled output holds the sequencer in its output step; the next input beat is
// taken while the last result still waits in the output register.
module lrn_backward_channel_window_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] x_value,
    input  logic signed [31:0] out_value,
    input  logic [30:0]        mid_value,
    input  logic signed [31:0] out_grad,
    input  logic               last_channel,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] x_grad,
    output logic               last_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    lrnbw_pkg::cfg_t       cfg_reg;
    lrnbw_pkg::dp_cmd_t    cmd;
    lrnbw_pkg::dp_status_t status;
    logic                  wr_en;
    lrnbw_pkg::reg_idx_t   reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = lrnbw_pkg::reg_idx_t'(paddr[3:2]);

    // Register file: write on the access beat, drop writes to unused addresses.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_size   <= lrnbw_pkg::WINDOW_SIZE_RST;
            cfg_reg.alpha_scale   <= lrnbw_pkg::ALPHA_SCALE_RST;
            cfg_reg.beta_exponent <= lrnbw_pkg::BETA_EXPONENT_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                lrnbw_pkg::REG_WINDOW_SIZE:   cfg_reg.window_size   <= pwdata[3:0];
                lrnbw_pkg::REG_ALPHA_SCALE:   cfg_reg.alpha_scale   <= pwdata;
                lrnbw_pkg::REG_BETA_EXPONENT: cfg_reg.beta_exponent <= pwdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            lrnbw_pkg::REG_WINDOW_SIZE:   prdata = {28'd0, cfg_reg.window_size};
            lrnbw_pkg::REG_ALPHA_SCALE:   prdata = cfg_reg.alpha_scale;
            lrnbw_pkg::REG_BETA_EXPONENT: prdata = {16'd0, cfg_reg.beta_exponent};
            default:                      prdata = 32'd0;
        endcase
    end

    lrnbw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    lrnbw_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg          (cfg_reg),
        .x_value      (x_value),
        .out_value    (out_value),
        .mid_value    (mid_value),
        .out_grad     (out_grad),
        .last_channel (last_channel),
        .x_grad       (x_grad),
        .last_result  (last_result),
        .out_valid    (out_valid),
        .out_ready    (out_ready)
    );

endmodule

### rtl/lrnbw_divider.sv
// Restoring divider, one quotient bit per cycle, for the window term |g*o|/mid.
// Uses lrnbw_pkg for the step count.
module lrnbw_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [62:0] num,
    input  logic [30:0] den,
    output logic        done,
    output logic [62:0] quot
);

    logic [31:0] rem_reg;
    logic [62:0] quo_reg;
    logic [30:0] den_reg;
    logic [lrnbw_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [31:0] rem_sh;
    logic        ge;

    assign rem_sh = {rem_reg[30:0], quo_reg[62]};
    assign ge     = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == lrnbw_pkg::DIV_CNT_W'(lrnbw_pkg::DIV_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= 32'd0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
            quo_reg <= {quo_reg[61:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

### rtl/lrnbw_datapath.sv
// Datapath: power chain, window and pending stores, correction multiply, result register.
// Uses lrnbw_pkg and lrnbw_divider.
module lrnbw_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lrnbw_pkg::dp_cmd_t    cmd,
    output lrnbw_pkg::dp_status_t status,
    input  lrnbw_pkg::cfg_t       cfg,
    input  logic signed [31:0]    x_value,
    input  logic signed [31:0]    out_value,
    input  logic [30:0]           mid_value,
    input  logic signed [31:0]    out_grad,
    input  logic                  last_channel,
    output logic signed [31:0]    x_grad,
    output logic                  last_result,
    output logic                  out_valid,
    input  logic                  out_ready
);

    localparam int WI = lrnbw_pkg::WIN_IDX_W;
    localparam int PI = lrnbw_pkg::PEND_IDX_W;
    localparam int SW = lrnbw_pkg::SUM_W;
    localparam int MW = lrnbw_pkg::MUL_W;
    localparam int IW = lrnbw_pkg::ITER_W;
    localparam logic [MW-1:0] RND_HALF = MW'(1) << 58;

    // item registers
    logic [31:0] x_reg;
    logic signed [31:0] g_reg;
    logic        term_neg_reg;
    logic        last_reg;
    logic [31:0] ny_reg;
    logic [4:0]  ne_reg;
    logic [lrnbw_pkg::FRAC_BITS-1:0] frac_reg;
    logic [lrnbw_pkg::FRAC_BITS-1:0] f_reg;
    logic [IW-1:0] iter_reg;
    logic signed [11:0] ip_reg;
    logic [31:0] p_reg;
    logic [63:0] v_reg;
    logic [31:0] direct_reg;

    // position state
    logic [31:0] term_win_reg [lrnbw_pkg::MAX_WINDOW];
    logic [31:0] pdir_reg [lrnbw_pkg::PEND_DEPTH];
    logic [31:0] pin_reg  [lrnbw_pkg::PEND_DEPTH];
    logic [lrnbw_pkg::CNT_W-1:0] cnt_reg;

    // emission
    logic [PI-1:0] d_reg;
    logic [WI-1:0] idx_reg;
    logic signed [SW-1:0] sum_reg;
    logic [MW-1:0] mul_a_reg;
    logic [35:0]   mul_b_reg;
    logic [MW-1:0] acc_reg;
    logic [31:0]   res_reg;

    logic        out_valid_reg;
    logic [31:0] x_grad_reg;
    logic        last_result_reg;

    // divider hookup
    logic [30:0] m_eff;
    logic [31:0] gmag_in;
    logic [31:0] omag_in;
    logic [62:0] div_num;
    logic        div_done;
    logic [62:0] div_quot;

    function automatic logic [lrnbw_pkg::CNT_W-1:0] CNT_W_EXT(input logic [2:0] v);
        return lrnbw_pkg::CNT_W'(v);
    endfunction

    assign m_eff   = (mid_value == 31'd0) ? 31'd1 : mid_value;
    assign gmag_in = out_grad[31] ? (32'd0 - out_grad) : out_grad;
    assign omag_in = out_value[31] ? (32'd0 - out_value) : out_value;
    assign div_num = 63'(64'(gmag_in) * 64'(omag_in));

    lrnbw_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.load),
        .num   (div_num),
        .den   (m_eff),
        .done  (div_done),
        .quot  (div_quot)
    );

    // log2 squaring step
    logic [63:0] sq;
    logic [32:0] sqs;
    assign sq  = 64'(ny_reg) * 64'(ny_reg);
    assign sqs = sq[63:31];

    // -beta*log2 scaling
    logic signed [5:0]  lg_int;
    logic signed [29:0] lg;
    logic signed [46:0] bprod;
    logic signed [47:0] negp;
    assign lg_int = $signed({1'b0, ne_reg}) - 6'sd16;
    assign lg     = {lg_int, frac_reg};
    assign bprod  = $signed({1'b0, cfg.beta_exponent}) * lg;
    assign negp   = 48'sd0 - 48'(bprod);

    // exp2 fraction step
    logic [63:0] pr;
    assign pr = 64'(p_reg) * 64'(lrnbw_pkg::ROOT_TBL[iter_reg]);

    // scale by 2^(ip-30) with half-up rounding
    logic [31:0] gmag;
    logic signed [12:0] s_exp;
    logic signed [12:0] r_neg;
    logic [5:0]  rsh;
    logic [64:0] vrnd;
    logic [63:0] mag;
    logic        mag_big;
    assign gmag = g_reg[31] ? (32'd0 - g_reg) : g_reg;

    always_comb
    begin
        s_exp = 13'(ip_reg) - 13'sd30;
        r_neg = 13'sd0 - s_exp;
        rsh   = 6'd0;
        vrnd  = 65'd0;
        if (v_reg == 64'd0)
        begin
            mag = 64'd0;
        end
        else if (!s_exp[12])
        begin
            if (s_exp >= 13'sd32)
            begin
                mag = 64'h1_0000_0000;
            end
            else
            begin
                rsh = 6'd32 - {1'b0, s_exp[4:0]};
                if ((v_reg >> rsh) != 64'd0)
                begin
                    mag = 64'h1_0000_0000;
                end
                else
                begin
                    mag = v_reg << s_exp[4:0];
                end
            end
        end
        else if (r_neg > 13'sd63)
        begin
            mag = 64'd0;
        end
        else
        begin
            rsh  = r_neg[5:0];
            vrnd = (65'(v_reg) + (65'd1 << (rsh - 6'd1))) >> rsh;
            mag  = vrnd[63:0];
        end
        mag_big = mag[63:31] != 33'd0;
    end

    // window geometry
    logic [3:0] n_eff;
    logic [2:0] h_w;
    logic [2:0] lag_w;
    logic [lrnbw_pkg::CNT_W-1:0] cntm1;
    logic [2:0] dmax;
    logic [3:0] dh;
    logic [WI-1:0] hi_k;

    always_comb
    begin
        if (cfg.window_size == 4'd0)
        begin
            n_eff = 4'd1;
        end
        else if (5'(cfg.window_size) > 5'(lrnbw_pkg::MAX_WINDOW))
        begin
            n_eff = 4'(lrnbw_pkg::MAX_WINDOW);
        end
        else
        begin
            n_eff = cfg.window_size;
        end
        h_w   = 3'((n_eff - 4'd1) >> 1);
        lag_w = 3'(n_eff - 4'd1 - {1'b0, h_w});
        cntm1 = cnt_reg - 1'b1;
        dmax  = (CNT_W_EXT(lag_w) < cntm1) ? lag_w : cntm1[2:0];
        dh    = 4'(d_reg) + 4'(h_w);
        if (8'(dh) > cntm1)
        begin
            hi_k = cntm1[WI-1:0];
        end
        else
        begin
            hi_k = dh;
        end
        if (hi_k > WI'(lrnbw_pkg::MAX_WINDOW - 1))
        begin
            hi_k = WI'(lrnbw_pkg::MAX_WINDOW - 1);
        end
    end

    // term from the quotient
    logic [31:0] term;
    logic        q_big;
    assign q_big = div_quot[62:31] != 32'd0;
    assign term  = term_neg_reg ?
                   (q_big ? 32'h8000_0000 : (32'd0 - div_quot[31:0])) :
                   (q_big ? 32'h7FFF_FFFF : div_quot[31:0]);

    // correction and final result
    logic [31:0] xsel;
    logic [31:0] xmag;
    logic [35:0] smag;
    logic [MW-1:0] rnd;
    logic [MW-60:0] res_hi;
    logic [32:0] cm;
    logic signed [33:0] dsum;
    logic [31:0] fin_val;

    assign xsel = pin_reg[d_reg];
    assign xmag = xsel[31] ? (32'd0 - xsel) : xsel;
    assign smag = sum_reg[SW-1] ? 36'(-sum_reg) : 36'(sum_reg);

    always_comb
    begin
        rnd    = acc_reg + RND_HALF;
        res_hi = rnd[MW-1:59];
        cm     = (res_hi > (MW-59)'(64'h1_0000_0000)) ? 33'h1_0000_0000 : res_hi[32:0];
        if (sum_reg[SW-1] != xsel[31])
        begin
            dsum = 34'($signed(pdir_reg[d_reg])) + $signed({1'b0, cm});
        end
        else
        begin
            dsum = 34'($signed(pdir_reg[d_reg])) - $signed({1'b0, cm});
        end
        if (dsum > 34'sd2147483647)
        begin
            fin_val = 32'h7FFF_FFFF;
        end
        else if (dsum < -34'sd2147483648)
        begin
            fin_val = 32'h8000_0000;
        end
        else
        begin
            fin_val = dsum[31:0];
        end
    end

    // control-state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.push && (cnt_reg != {lrnbw_pkg::CNT_W{1'b1}}))
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (cmd.clear_cnt)
            begin
                cnt_reg <= '0;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg        <= x_value;
            g_reg        <= out_grad;
            term_neg_reg <= out_grad[31] ^ out_value[31];
            last_reg     <= last_channel;
            ny_reg       <= {m_eff, 1'b0};
            ne_reg       <= 5'd30;
            frac_reg     <= '0;
            iter_reg     <= '0;
        end
        if (cmd.norm_step)
        begin
            ny_reg <= ny_reg << 1;
            ne_reg <= ne_reg - 1'b1;
        end
        if (cmd.log_step)
        begin
            iter_reg <= iter_reg + 1'b1;
            if (sqs[32])
            begin
                ny_reg   <= sqs[32:1];
                frac_reg <= {frac_reg[lrnbw_pkg::FRAC_BITS-2:0], 1'b1};
            end
            else
            begin
                ny_reg   <= sqs[31:0];
                frac_reg <= {frac_reg[lrnbw_pkg::FRAC_BITS-2:0], 1'b0};
            end
        end
        if (cmd.beta_calc)
        begin
            ip_reg   <= negp[47:36];
            f_reg    <= negp[35:12];
            p_reg    <= 32'h4000_0000;
            iter_reg <= '0;
        end
        if (cmd.exp_step)
        begin
            iter_reg <= iter_reg + 1'b1;
            f_reg    <= f_reg << 1;
            if (f_reg[lrnbw_pkg::FRAC_BITS-1])
            begin
                p_reg <= pr[61:30];
            end
        end
        if (cmd.vmul)
        begin
            v_reg <= 64'(p_reg) * 64'(gmag);
        end
        if (cmd.vshift)
        begin
            direct_reg <= g_reg[31] ?
                          (mag_big ? 32'h8000_0000 : (32'd0 - mag[31:0])) :
                          (mag_big ? 32'h7FFF_FFFF : mag[31:0]);
        end
        if (cmd.push)
        begin
            term_win_reg[0] <= term;
            for (int k = 1; k < lrnbw_pkg::MAX_WINDOW; k++)
            begin
                term_win_reg[k] <= term_win_reg[k-1];
            end
            pdir_reg[0] <= direct_reg;
            pin_reg[0]  <= x_reg;
            for (int k = 1; k < lrnbw_pkg::PEND_DEPTH; k++)
            begin
                pdir_reg[k] <= pdir_reg[k-1];
                pin_reg[k]  <= pin_reg[k-1];
            end
        end
        if (cmd.plan)
        begin
            d_reg   <= last_reg ? dmax : lag_w;
            sum_reg <= '0;
            idx_reg <= '0;
        end
        if (cmd.next_emit)
        begin
            d_reg   <= d_reg - 1'b1;
            sum_reg <= '0;
            idx_reg <= '0;
        end
        if (cmd.sum_step)
        begin
            sum_reg <= sum_reg + SW'($signed(term_win_reg[idx_reg]));
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.mul_set)
        begin
            mul_a_reg <= MW'(48'(cfg.alpha_scale) * 48'(cfg.beta_exponent));
            mul_b_reg <= 36'(xmag);
            acc_reg   <= '0;
        end
        if (cmd.mul_step)
        begin
            if (mul_b_reg[0])
            begin
                acc_reg <= acc_reg + mul_a_reg;
            end
            mul_a_reg <= mul_a_reg << 1;
            mul_b_reg <= mul_b_reg >> 1;
        end
        if (cmd.mul2_set)
        begin
            mul_a_reg <= acc_reg;
            mul_b_reg <= smag;
            acc_reg   <= '0;
        end
        if (cmd.finish)
        begin
            res_reg <= fin_val;
        end
        if (cmd.out_load)
        begin
            x_grad_reg      <= res_reg;
            last_result_reg <= last_reg && (d_reg == '0);
        end
    end

    always_comb
    begin
        status.norm_done = ny_reg[31];
        status.iter_last = iter_reg == IW'(lrnbw_pkg::FRAC_BITS - 1);
        status.div_done  = div_done;
        status.emit_req  = last_reg || (cnt_reg > CNT_W_EXT(lag_w));
        status.last_item = last_reg;
        status.sum_done  = idx_reg == hi_k;
        status.mulb_zero = mul_b_reg == 36'd0;
        status.out_free  = !out_valid_reg || out_ready;
        status.more_emit = last_reg && (d_reg != '0);
    end

    assign out_valid   = out_valid_reg;
    assign x_grad      = x_grad_reg;
    assign last_result = last_result_reg;

endmodule

### rtl/lrnbw_ctrl.sv
// Sequencer for one channel: power chain, push, then one pass per emitted result.
// Uses lrnbw_pkg command, status and state types.
module lrnbw_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  lrnbw_pkg::dp_status_t status,
    output lrnbw_pkg::dp_cmd_t    cmd
);

    lrnbw_pkg::state_t state_reg;
    lrnbw_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lrnbw_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            lrnbw_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = lrnbw_pkg::ST_NORM;
                end
            end
            lrnbw_pkg::ST_NORM:
            begin
                if (status.norm_done)
                begin
                    state_next = lrnbw_pkg::ST_LOG;
                end
                else
                begin
                    cmd.norm_step = 1'b1;
                end
            end
            lrnbw_pkg::ST_LOG:
            begin
                cmd.log_step = 1'b1;
                if (status.iter_last)
                begin
                    state_next = lrnbw_pkg::ST_BETA;
                end
            end
            lrnbw_pkg::ST_BETA:
            begin
                cmd.beta_calc = 1'b1;
                state_next    = lrnbw_pkg::ST_EXP;
            end
            lrnbw_pkg::ST_EXP:
            begin
                cmd.exp_step = 1'b1;
                if (status.iter_last)
                begin
                    state_next = lrnbw_pkg::ST_VMUL;
                end
            end
            lrnbw_pkg::ST_VMUL:
            begin
                cmd.vmul   = 1'b1;
                state_next = lrnbw_pkg::ST_VSHIFT;
            end
            lrnbw_pkg::ST_VSHIFT:
            begin
                cmd.vshift = 1'b1;
                state_next = lrnbw_pkg::ST_WDIV;
            end
            lrnbw_pkg::ST_WDIV:
            begin
                if (status.div_done)
                begin
                    cmd.push   = 1'b1;
                    state_next = lrnbw_pkg::ST_PLAN;
                end
            end
            lrnbw_pkg::ST_PLAN:
            begin
                cmd.plan   = 1'b1;
                state_next = status.emit_req ? lrnbw_pkg::ST_SUM : lrnbw_pkg::ST_IDLE;
            end
            lrnbw_pkg::ST_SUM:
            begin
                cmd.sum_step = 1'b1;
                if (status.sum_done)
                begin
                    state_next = lrnbw_pkg::ST_MSET;
                end
            end
            lrnbw_pkg::ST_MSET:
            begin
                cmd.mul_set = 1'b1;
                state_next  = lrnbw_pkg::ST_MUL1;
            end
            lrnbw_pkg::ST_MUL1:
            begin
                if (status.mulb_zero)
                begin
                    cmd.mul2_set = 1'b1;
                    state_next   = lrnbw_pkg::ST_MUL2;
                end
                else
                begin
                    cmd.mul_step = 1'b1;
                end
            end
            lrnbw_pkg::ST_MUL2:
            begin
                if (status.mulb_zero)
                begin
                    state_next = lrnbw_pkg::ST_FIN;
                end
                else
                begin
                    cmd.mul_step = 1'b1;
                end
            end
            lrnbw_pkg::ST_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = lrnbw_pkg::ST_OUT;
            end
            lrnbw_pkg::ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (status.more_emit)
                    begin
                        cmd.next_emit = 1'b1;
                        state_next    = lrnbw_pkg::ST_SUM;
                    end
                    else
                    begin
                        cmd.clear_cnt = status.last_item;
                        state_next    = lrnbw_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = lrnbw_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/lrnbw_checker.sv
// Port-level checks for the LRN backward channel window, bound to the top level.
// No package dependencies.
module lrnbw_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] x_grad,
    input logic        last_result,
    input logic        pready
);

    a_pready_high: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(x_grad) && $stable(last_result))
        else $error("stalled result changed");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second input beat taken while busy");

    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared while idle");

endmodule

bind lrn_backward_channel_window_top lrnbw_checker u_chk (.*);

### test/lrn_backward_channel_window_top_tb.sv
// Self-checking testbench for the LRN backward channel window block.
// Depends on lrnbw_pkg and lrn_backward_channel_window_top; needs nothing else.
// Predicts every gradient beat in fixed point and checks each one as it leaves the block.
module lrn_backward_channel_window_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HIST_DEPTH = 8;
    localparam longint unsigned MAG_CLAMP = 64'h1_0000_0000;

    // One expected gradient beat.
    typedef struct {
        logic [31:0] grad;
        logic        last;
    } grad_beat_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [31:0] x_value = '0;
    logic signed [31:0] out_value = '0;
    logic [30:0]        mid_value = '0;
    logic signed [31:0] out_grad = '0;
    logic               last_channel = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] x_grad;
    logic               last_result;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [3:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    // Shadow of the block's registers and per-position history.
    logic [3:0]  win_len_reg;
    logic [31:0] alpha_reg;
    logic [15:0] beta_reg;
    logic [31:0] term_hist [lrnbw_pkg::MAX_WINDOW];
    logic [31:0] scaled_grad_hist [HIST_DEPTH];
    logic [31:0] x_hist [HIST_DEPTH];
    int          chan_seen;

    grad_beat_t grad_queue [$];
    int         mismatch_cnt = 0;
    int         tx_idle_pct = 0;
    int         rx_idle_pct = 0;

    lrn_backward_channel_window_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .x_value      (x_value),
        .out_value    (out_value),
        .mid_value    (mid_value),
        .out_grad     (out_grad),
        .last_channel (last_channel),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .x_grad       (x_grad),
        .last_result  (last_result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Generous bound: several times the slowest legal run with the heaviest stalls.
    initial
    begin
        #40ms;
        $display("end of test: mismatches");
        $finish;
    end

    // ---------------------------------------------------------------- fixed-point helpers

    function automatic longint sx32(logic [31:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint unsigned abs64(longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Clamp a magnitude to 2^32, apply the sign, then saturate to 32 bits.
    function automatic longint signed_clamp(longint unsigned mag, bit neg);
        longint v;
        if (mag > MAG_CLAMP)
            mag = MAG_CLAMP;
        v = longint'(mag);
        return clamp32(neg ? -v : v);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // log2 of a Q16.16 value in Q8.24: leading one, then 24 mantissa squarings.
    function automatic longint log2_q824(logic [31:0] m);
        int              e;
        int              k;
        longint unsigned y;
        longint          fr;
        e  = 30;
        fr = 0;
        while (e > 0 && m[e] == 1'b0)
            e--;
        y = {32'd0, m} << (31 - e);
        for (k = 0; k < lrnbw_pkg::FRAC_BITS; k++)
        begin
            y  = (y * y) >> 31;
            fr = fr << 1;
            if (y >= MAG_CLAMP)
            begin
                fr = fr | 1;
                y  = y >> 1;
            end
        end
        return longint'(e - 16) * 16777216 + fr;
    endfunction

    // mid^-beta * gout, rounded half up in magnitude and saturated.
    function automatic logic [31:0] scaled_gradient(logic [31:0] m, longint g, logic [15:0] beta);
        longint          lg;
        longint          t;
        longint          ip;
        longint          sh;
        logic [23:0]     f;
        longint unsigned p;
        longint unsigned r;
        longint unsigned v;
        longint unsigned mag;
        int              k;
        lg = log2_q824(m);
        t  = (-longint'(beta) * lg) >>> 12;
        ip = t >>> 24;
        f  = t[23:0];
        p  = 64'd1 << 30;
        r  = 64'd1 << 31;
        for (k = 1; k <= lrnbw_pkg::FRAC_BITS; k++)
        begin
            r = int_sqrt(r << 30);
            if (f[lrnbw_pkg::FRAC_BITS - k])
                p = (p * r) >> 30;
        end
        v  = p * abs64(g);
        sh = ip - 30;
        if (v == 0)
            mag = 0;
        else if (sh >= 0)
        begin
            if (sh >= 32 || v >= (MAG_CLAMP >> sh))
                mag = MAG_CLAMP;
            else
                mag = v << sh;
        end
        else if (-sh > 63)
            mag = 0;
        else
            mag = (v + (64'd1 << (-sh - 1))) >> (-sh);
        return 32'(signed_clamp(mag, g < 0));
    endfunction

    // Gradient of the channel d places back in history, window reaching h behind.
    function automatic logic [31:0] window_gradient(int d, int h);
        int              hi_k;
        int              k;
        longint          s;
        longint          xi;
        longint          dir;
        logic [127:0]    prod;
        longint unsigned res;
        longint unsigned cm;
        hi_k = d + h;
        if (hi_k > chan_seen - 1)
            hi_k = chan_seen - 1;
        if (hi_k > lrnbw_pkg::MAX_WINDOW - 1)
            hi_k = lrnbw_pkg::MAX_WINDOW - 1;
        s = 0;
        for (k = 0; k <= hi_k; k++)
            s += sx32(term_hist[k]);
        xi   = sx32(x_hist[d]);
        dir  = sx32(scaled_grad_hist[d]);
        prod = 128'(alpha_reg) * 128'(beta_reg) * 128'(abs64(s)) * 128'(abs64(xi));
        prod = prod + (128'd1 << 58);
        res  = 64'(prod >> 59);
        cm   = (res > MAG_CLAMP) ? MAG_CLAMP : res;
        if ((s < 0) != (xi < 0))
            dir += longint'(cm);
        else
            dir -= longint'(cm);
        return 32'(clamp32(dir));
    endfunction

    // Advance the shadow by one accepted channel and queue the gradients it releases.
    function automatic void predict_channel(logic [31:0] xv, logic [31:0] ov, logic [30:0] mv,
                                            logic [31:0] gv, logic lastv);
        longint          x;
        longint          o;
        longint          g;
        logic [31:0]     m;
        longint unsigned q;
        int              k;
        int              n;
        int              h;
        int              lag;
        int              dmax;
        int              d;
        grad_beat_t      b;
        x = sx32(xv);
        o = sx32(ov);
        g = sx32(gv);
        m = {1'b0, mv};
        if (m == 0)
            m = 1;
        q = (abs64(g) * abs64(o)) / m;
        for (k = lrnbw_pkg::MAX_WINDOW - 1; k > 0; k--)
            term_hist[k] = term_hist[k - 1];
        term_hist[0] = 32'(signed_clamp(q, (g < 0) != (o < 0)));
        for (k = HIST_DEPTH - 1; k > 0; k--)
        begin
            scaled_grad_hist[k] = scaled_grad_hist[k - 1];
            x_hist[k]           = x_hist[k - 1];
        end
        scaled_grad_hist[0] = scaled_gradient(m, g, beta_reg);
        x_hist[0]           = xv;
        if (chan_seen < 255)
            chan_seen++;
        n = win_len_reg;
        if (n < 1)
            n = 1;
        if (n > lrnbw_pkg::MAX_WINDOW)
            n = lrnbw_pkg::MAX_WINDOW;
        h   = (n - 1) / 2;
        lag = n - 1 - h;
        if (!lastv)
        begin
            if (chan_seen > lag)
            begin
                b.grad = window_gradient(lag, h);
                b.last = 1'b0;
                grad_queue.push_back(b);
            end
            return;
        end
        // Flush every channel still waiting, oldest first.
        dmax = (lag < chan_seen - 1) ? lag : chan_seen - 1;
        for (d = dmax; d >= 0; d--)
        begin
            b.grad = window_gradient(d, h);
            b.last = (d == 0);
            grad_queue.push_back(b);
        end
        chan_seen = 0;
    endfunction

    // ---------------------------------------------------------------- result checker

    always @(posedge clk)
    begin
        grad_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (grad_queue.size() == 0)
            begin
                mismatch_cnt++;
                $display("%0t: unexpected gradient beat, actual x_grad %h last %b",
                         $realtime, x_grad, last_result);
            end
            else
            begin
                want = grad_queue.pop_front();
                if (x_grad !== want.grad)
                begin
                    mismatch_cnt++;
                    $display("%0t: x_grad expected %h actual %h", $realtime, want.grad, x_grad);
                end
                if (last_result !== want.last)
                begin
                    mismatch_cnt++;
                    $display("%0t: last_result expected %b actual %b",
                             $realtime, want.last, last_result);
                end
            end
        end
        // Stall the output at the current receiver idle rate.
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // ---------------------------------------------------------------- drivers

    // Write one register through a setup and an access cycle; mirror it in the shadow.
    task automatic reg_write(lrnbw_pkg::reg_idx_t idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            lrnbw_pkg::REG_WINDOW_SIZE:   win_len_reg = val[3:0];
            lrnbw_pkg::REG_ALPHA_SCALE:   alpha_reg = val;
            lrnbw_pkg::REG_BETA_EXPONENT: beta_reg = val[15:0];
            default:                      ;
        endcase
    endtask

    // Read one register back and compare it with the shadow.
    task automatic reg_check(lrnbw_pkg::reg_idx_t idx);
        logic [31:0] want;
        case (idx)
            lrnbw_pkg::REG_WINDOW_SIZE: want = {28'd0, win_len_reg};
            lrnbw_pkg::REG_ALPHA_SCALE: want = alpha_reg;
            default:                    want = {16'd0, beta_reg};
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== want)
        begin
            mismatch_cnt++;
            $display("%0t: register %0d expected %h actual %h", $realtime, idx, want, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Send one channel beat; valid stays up between back-to-back beats.
    task automatic send_channel(logic [31:0] xv, logic [31:0] ov, logic [30:0] mv,
                                logic [31:0] gv, logic lastv);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct && gap < 40)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        x_value      <= xv;
        out_value    <= ov;
        mid_value    <= mv;
        out_grad     <= gv;
        last_channel <= lastv;
        do
            @(posedge clk);
        while (!in_ready);
        predict_channel(xv, ov, mv, gv, lastv);
    endtask

    // Drop valid, wait until every predicted beat has left, then let the sequencer settle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (grad_queue.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return $urandom_range(65536 * 8) - 65536 * 4;
            3:       return $urandom_range(1024) - 512;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [30:0] rand_mid();
        case ($urandom_range(4))
            0:       return 31'($urandom_range(3));
            1:       return 31'h7FFF_FFFF;
            2:       return 31'($urandom_range(65536 * 4, 4096));
            default: return 31'($urandom());
        endcase
    endfunction

    task automatic send_position(int len);
        int k;
        for (k = 0; k < len; k++)
            send_channel(rand_word(), rand_word(), rand_mid(), rand_word(), k == len - 1);
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_registers();
        reg_check(lrnbw_pkg::REG_WINDOW_SIZE);
        reg_check(lrnbw_pkg::REG_ALPHA_SCALE);
        reg_check(lrnbw_pkg::REG_BETA_EXPONENT);
        reg_write(lrnbw_pkg::REG_WINDOW_SIZE, 32'd15);
        reg_write(lrnbw_pkg::REG_ALPHA_SCALE, 32'hFFFF_FFFF);
        reg_write(lrnbw_pkg::REG_BETA_EXPONENT, 32'h0000_FFFF);
        reg_check(lrnbw_pkg::REG_WINDOW_SIZE);
        reg_check(lrnbw_pkg::REG_ALPHA_SCALE);
        reg_check(lrnbw_pkg::REG_BETA_EXPONENT);
        reg_write(lrnbw_pkg::REG_WINDOW_SIZE, 32'(lrnbw_pkg::WINDOW_SIZE_RST));
        reg_write(lrnbw_pkg::REG_ALPHA_SCALE, lrnbw_pkg::ALPHA_SCALE_RST);
        reg_write(lrnbw_pkg::REG_BETA_EXPONENT, 32'(lrnbw_pkg::BETA_EXPONENT_RST));
    endtask

    task automatic test_directed();
        // Default window: field extremes, zero and smallest and largest mid.
        send_channel(32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'd0, 32'h8000_0000, 1'b0);
        send_channel(32'h8000_0000, 32'h8000_0000, 31'd1, 32'h7FFF_FFFF, 1'b0);
        send_channel(32'h0001_0000, 32'hFFFF_0000, 31'h7FFF_FFFF, 32'd0, 1'b0);
        send_channel(32'hFFFF_FFFF, 32'h0000_8000, 31'h0001_0000, 32'hFFFF_FFFF, 1'b0);
        send_channel(32'd0, 32'h0002_0000, 31'h0000_4000, 32'h0001_0000, 1'b0);
        send_channel(32'h1234_5678, 32'hEDCB_A988, 31'h5555_5555, 32'hAAAA_AAAA, 1'b1);
        wait_idle();
        // Window zero behaves as one.
        reg_write(lrnbw_pkg::REG_WINDOW_SIZE, 32'd0);
        send_position(2);
        wait_idle();
        // Even window reaches one channel further ahead.
        reg_write(lrnbw_pkg::REG_WINDOW_SIZE, 32'd2);
        send_position(3);
        wait_idle();
        // Widest window with strongest alpha and beta; position shorter than the lag.
        reg_write(lrnbw_pkg::REG_WINDOW_SIZE, 32'd15);
        reg_write(lrnbw_pkg::REG_ALPHA_SCALE, 32'hFFFF_FFFF);
        reg_write(lrnbw_pkg::REG_BETA_EXPONENT, 32'h0000_FFFF);
        send_position(4);
        wait_idle();
        // Single-channel position with alpha and beta at zero.
        reg_write(lrnbw_pkg::REG_ALPHA_SCALE, 32'd0);
        reg_write(lrnbw_pkg::REG_BETA_EXPONENT, 32'd0);
        send_position(1);
        wait_idle();
        // Registers changed in the middle of a position.
        reg_write(lrnbw_pkg::REG_WINDOW_SIZE, 32'd5);
        reg_write(lrnbw_pkg::REG_ALPHA_SCALE, lrnbw_pkg::ALPHA_SCALE_RST);
        reg_write(lrnbw_pkg::REG_BETA_EXPONENT, 32'(lrnbw_pkg::BETA_EXPONENT_RST));
        send_channel(rand_word(), rand_word(), rand_mid(), rand_word(), 1'b0);
        send_channel(rand_word(), rand_word(), rand_mid(), rand_word(), 1'b0);
        send_channel(rand_word(), rand_word(), rand_mid(), rand_word(), 1'b0);
        wait_idle();
        reg_write(lrnbw_pkg::REG_WINDOW_SIZE, 32'd3);
        reg_write(lrnbw_pkg::REG_BETA_EXPONENT, 32'd8192);
        send_position(2);
        wait_idle();
    endtask

    // Long position: many more channels than the window holds.
    task automatic test_long_position();
        reg_write(lrnbw_pkg::REG_WINDOW_SIZE, 32'd1);
        send_position(40);
        wait_idle();
    endtask

    task automatic randomize_registers();
        case ($urandom_range(4))
            0:       reg_write(lrnbw_pkg::REG_WINDOW_SIZE, 32'd0);
            1:       reg_write(lrnbw_pkg::REG_WINDOW_SIZE, 32'd15);
            2:       reg_write(lrnbw_pkg::REG_WINDOW_SIZE, 32'd2);
            default: reg_write(lrnbw_pkg::REG_WINDOW_SIZE, $urandom_range(15));
        endcase
        case ($urandom_range(3))
            0:       reg_write(lrnbw_pkg::REG_ALPHA_SCALE, 32'hFFFF_FFFF);
            1:       reg_write(lrnbw_pkg::REG_ALPHA_SCALE, lrnbw_pkg::ALPHA_SCALE_RST);
            default: reg_write(lrnbw_pkg::REG_ALPHA_SCALE, $urandom());
        endcase
        case ($urandom_range(3))
            0:       reg_write(lrnbw_pkg::REG_BETA_EXPONENT, 32'h0000_FFFF);
            1:       reg_write(lrnbw_pkg::REG_BETA_EXPONENT, 32'd0);
            default: reg_write(lrnbw_pkg::REG_BETA_EXPONENT, $urandom_range(8192));
        endcase
    endtask

    task automatic test_random_positions(int tx_pct, int rx_pct, int items);
        int sent;
        int len;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        sent = 0;
        while (sent < items)
        begin
            randomize_registers();
            len = ($urandom_range(9) == 0) ? 1 : $urandom_range(16, 2);
            send_position(len);
            sent += len;
            wait_idle();
        end
    endtask

    initial
    begin
        win_len_reg = lrnbw_pkg::WINDOW_SIZE_RST;
        alpha_reg   = lrnbw_pkg::ALPHA_SCALE_RST;
        beta_reg    = lrnbw_pkg::BETA_EXPONENT_RST;
        chan_seen   = 0;
        foreach (term_hist[k])
            term_hist[k] = '0;
        foreach (x_hist[k])
        begin
            x_hist[k]           = '0;
            scaled_grad_hist[k] = '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 8;
        rx_idle_pct = 52;
        test_registers();
        test_directed();
        test_long_position();
        test_random_positions(8, 52, 45);
        test_random_positions(52, 8, 45);
        test_random_positions(0, 0, 45);

        in_valid <= 1'b0;
        repeat (300) @(posedge clk);
        if (mismatch_cnt == 0 && grad_queue.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
